### rtl/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int AddrW = 12;
  localparam int SizeW = 13;
  localparam int StatW = 2;
  localparam int OrdW  = 5;
  localparam int NeedW = 14;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_NOMEM   = 2'd1;
  localparam logic [StatW-1:0] ST_TOOBIG  = 2'd2;
  localparam logic [StatW-1:0] ST_IGNORED = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SIZE,
    OP_SINIT,
    OP_TREE_RD,
    OP_NEXT,
    OP_TAKE,
    OP_SPLIT,
    OP_ORD_WR,
    OP_FREE_INIT,
    OP_BUD_RD,
    OP_BUD_TAKE,
    OP_SET,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [StatW-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_free;
    logic too_big;
    logic tree_bit;
    logic last_in_level;
    logic top_level;
    logic split_done;
    logic free_bad;
    logic ord_bad;
    logic at_root;
  } dp_sts_t;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DEC   = 13'b0000000000100,
    S_SIZE  = 13'b0000000001000,
    S_SINIT = 13'b0000000010000,
    S_RD    = 13'b0000000100000,
    S_CHK   = 13'b0000001000000,
    S_SPLIT = 13'b0000010000000,
    S_FCHK  = 13'b0000100000000,
    S_FORD  = 13'b0001000000000,
    S_BRD   = 13'b0010000000000,
    S_BCHK  = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_e;

endpackage

### rtl/bba_if.sv
// Request and response channel interfaces of the buddy block allocator.
// Depends on bba_pkg for the field widths.
`timescale 1ns / 1ps

interface bba_req_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SizeW-1:0] req_size;
  logic [AddrW-1:0] free_addr;
  modport source (output valid, cmd, req_size, free_addr, input ready);
  modport sink (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] addr;
  logic [StatW-1:0] status;
  modport source (output valid, addr, status, input ready);
  modport sink (input valid, addr, status, output ready);
endinterface

### rtl/bba_datapath.sv
// Datapath of the buddy block allocator: free tree and block order memories,
// node and level registers, size rounding and the response register. Uses bba_pkg.
`timescale 1ns / 1ps

module bba_datapath
  import bba_pkg::*;
#(
  parameter int POOL_LOG     = 12,
  parameter int MIN_LOG      = 2,
  parameter int HEADER_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic             req_cmd_i,
  input  logic [SizeW-1:0] req_size_i,
  input  logic [AddrW-1:0] free_addr_i,
  output logic [AddrW-1:0] addr_o,
  output logic [StatW-1:0] status_o
);

  localparam int NW = POOL_LOG - MIN_LOG + 1;
  localparam int GW = POOL_LOG - MIN_LOG;
  localparam int PW = POOL_LOG + 1;

  logic tree_mem [2**NW];
  logic [OrdW-1:0] ord_mem [2**GW];

  logic             is_free_q;
  logic [SizeW-1:0] size_q;
  logic [AddrW-1:0] faddr_q;
  logic             started_q;
  logic [OrdW-1:0]  k_q, j_q, ord_q;
  logic             big_q, tree_q;
  logic [NW-1:0]    n_q, clr_q;
  logic [AddrW-1:0] addr_q;
  logic [StatW-1:0] status_q;

  logic [NeedW-1:0] need, need_m1;
  logic [OrdW-1:0]  bitlen, ksz;
  logic [NW:0]      n_plus;
  logic             last_lvl;
  logic [AddrW-1:0] foff;
  logic             free_bad;
  logic [GW-1:0]    g_free, g_alloc;
  logic [NW-1:0]    free_node;
  logic [PW-1:0]    aoff;
  logic [NW-1:0]    t_ra, t_wa;
  logic             t_we, t_wd;

  function automatic logic [NW-1:0] level_first(input logic [OrdW-1:0] lvl);
    level_first = NW'(1) << (OrdW'(POOL_LOG) - lvl);
  endfunction

  always_comb begin
    need    = NeedW'(size_q) + NeedW'(HEADER_BYTES);
    need_m1 = (need == '0) ? '0 : need - NeedW'(1);
    bitlen  = '0;
    for (int i = 0; i < NeedW; i++) begin
      if (need_m1[i]) begin
        bitlen = OrdW'(i + 1);
      end
    end
    ksz = (bitlen < OrdW'(MIN_LOG)) ? OrdW'(MIN_LOG) : bitlen;
  end

  assign n_plus   = {1'b0, n_q} + (NW + 1)'(1);
  assign last_lvl = (({1'b0, n_q} & n_plus) == '0);

  assign foff     = faddr_q - AddrW'(HEADER_BYTES);
  assign free_bad = (faddr_q == '0) || !started_q || (faddr_q < AddrW'(HEADER_BYTES)) ||
                    ((POOL_LOG < AddrW) && ((foff >> POOL_LOG) != '0)) ||
                    (foff[MIN_LOG-1:0] != '0);
  assign g_free    = GW'(foff >> MIN_LOG);
  assign free_node = NW'((PW'(foff) | (PW'(1) << POOL_LOG)) >> ord_q);
  assign aoff      = (PW'(n_q) << k_q) ^ (PW'(1) << POOL_LOG);
  assign g_alloc   = GW'(aoff >> MIN_LOG);

  always_comb begin
    t_ra = n_q;
    t_wa = n_q;
    t_we = 1'b0;
    t_wd = 1'b0;
    case (cmd_i.op)
      OP_CLEAR: begin
        t_we = 1'b1;
        t_wa = clr_q;
        t_wd = (clr_q == NW'(1));
      end
      OP_BUD_RD:   t_ra = n_q ^ NW'(1);
      OP_TAKE:     t_we = 1'b1;
      OP_SPLIT: begin
        t_we = 1'b1;
        t_wa = {n_q[NW-2:0], 1'b1};
        t_wd = 1'b1;
      end
      OP_BUD_TAKE: begin
        t_we = 1'b1;
        t_wa = n_q ^ NW'(1);
      end
      OP_SET: begin
        t_we = 1'b1;
        t_wd = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tree_mem[t_wa] <= t_wd;
    end
    tree_q <= tree_mem[t_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ORD_WR) begin
      ord_mem[g_alloc] <= k_q;
    end else if (cmd_i.op == OP_FREE_INIT) begin
      ord_mem[g_free] <= '0;
    end
    ord_q <= ord_mem[g_free];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      clr_q     <= '0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        clr_q <= clr_q + NW'(1);
      end
      if (cmd_i.op == OP_SIZE) begin
        started_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        is_free_q <= req_cmd_i;
        size_q    <= req_size_i;
        faddr_q   <= free_addr_i;
      end
      OP_SIZE: begin
        k_q   <= ksz;
        big_q <= (bitlen > OrdW'(POOL_LOG));
      end
      OP_SINIT: begin
        j_q <= k_q;
        n_q <= level_first(k_q);
      end
      OP_NEXT: begin
        if (last_lvl) begin
          j_q <= j_q + OrdW'(1);
          n_q <= level_first(j_q + OrdW'(1));
        end else begin
          n_q <= n_q + NW'(1);
        end
      end
      OP_SPLIT: begin
        n_q <= {n_q[NW-2:0], 1'b0};
        j_q <= j_q - OrdW'(1);
      end
      OP_FREE_INIT: n_q <= free_node;
      OP_BUD_TAKE:  n_q <= n_q >> 1;
      OP_EMIT: begin
        status_q <= cmd_i.status;
        addr_q   <= (cmd_i.status == ST_OK && is_free_q == CMD_ALLOC) ?
                    AddrW'(aoff) + AddrW'(HEADER_BYTES) : '0;
      end
      default: ;
    endcase
  end

  assign sts_o.clear_done    = &clr_q;
  assign sts_o.is_free       = (is_free_q == CMD_FREE);
  assign sts_o.too_big       = big_q;
  assign sts_o.tree_bit      = tree_q;
  assign sts_o.last_in_level = last_lvl;
  assign sts_o.top_level     = (j_q == OrdW'(POOL_LOG));
  assign sts_o.split_done    = (j_q == k_q);
  assign sts_o.free_bad      = free_bad;
  assign sts_o.ord_bad       = (ord_q < OrdW'(MIN_LOG)) || (ord_q > OrdW'(POOL_LOG)) ||
                               ((foff & ~({AddrW{1'b1}} << ord_q)) != '0);
  assign sts_o.at_root       = (n_q == NW'(1));

  assign addr_o   = addr_q;
  assign status_o = status_q;

endmodule

### rtl/bba_ctrl.sv
// Controller state machine of the buddy block allocator: clearing pass,
// search, split and merge sequencing, and the handshakes. Uses bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl
  import bba_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e           state_q, state_d;
  logic [StatW-1:0] st_q, st_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op     = OP_NONE;
    cmd_o.status = st_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC:  state_d = sts_i.is_free ? S_FCHK : S_SIZE;
      S_SIZE: begin
        cmd_o.op = OP_SIZE;
        state_d  = S_SINIT;
      end
      S_SINIT: begin
        if (sts_i.too_big) begin
          st_d    = ST_TOOBIG;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_SINIT;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        cmd_o.op = OP_TREE_RD;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (sts_i.tree_bit) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_SPLIT;
        end else if (sts_i.last_in_level && sts_i.top_level) begin
          st_d    = ST_NOMEM;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_NEXT;
          state_d  = S_RD;
        end
      end
      S_SPLIT: begin
        if (sts_i.split_done) begin
          cmd_o.op = OP_ORD_WR;
          st_d     = ST_OK;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = OP_SPLIT;
        end
      end
      S_FCHK: begin
        if (sts_i.free_bad) begin
          st_d    = ST_IGNORED;
          state_d = S_EMIT;
        end else begin
          state_d = S_FORD;
        end
      end
      S_FORD: begin
        if (sts_i.ord_bad) begin
          st_d    = ST_IGNORED;
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_FREE_INIT;
          state_d  = S_BRD;
        end
      end
      S_BRD: begin
        if (sts_i.at_root) begin
          cmd_o.op = OP_SET;
          st_d     = ST_OK;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = OP_BUD_RD;
          state_d  = S_BCHK;
        end
      end
      S_BCHK: begin
        if (sts_i.tree_bit) begin
          cmd_o.op = OP_BUD_TAKE;
          state_d  = S_BRD;
        end else begin
          cmd_o.op = OP_SET;
          st_d     = ST_OK;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_if, bba_ctrl and bba_datapath.
//
// After reset the block sweeps its free tree once, one node per cycle, before the
// first request beat is accepted. Requests are handled one at a time. An allocation
// examines tree nodes one by one in the search (free tree memory read, then test)
// and then splits the found block level by level; the worst case examines every
// node from the requested order up to the root. A free merges with its buddy level
// by level, at most POOL_LOG-MIN_LOG levels.
// A new request beat is accepted while the previous response beat still waits.
`timescale 1ns / 1ps

module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int POOL_LOG     = 12,
  parameter int MIN_LOG      = 2,
  parameter int HEADER_BYTES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  bba_datapath #(
    .POOL_LOG     (POOL_LOG),
    .MIN_LOG      (MIN_LOG),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .req_cmd_i   (req_i.cmd),
    .req_size_i  (req_i.req_size),
    .free_addr_i (req_i.free_addr),
    .addr_o      (rsp_o.addr),
    .status_o    (rsp_o.status)
  );

endmodule

### tb/sv/tb_buddy_block_allocator.sv
// Self-checking testbench of the buddy block allocator: directed rows, then random beats.
// Depends on bba_pkg, bba_if and buddy_block_allocator; it keeps its own model of the pool.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int PoolLog   = 12;
  localparam int MinLog    = 2;
  localparam int HdrBytes  = 16;
  localparam int Levels    = PoolLog - MinLog;
  localparam int Nodes     = 1 << (Levels + 1);
  localparam int Granules  = 1 << Levels;
  localparam int PoolBytes = 1 << PoolLog;
  localparam int NumRandom = 1730;
  localparam int CycleLimit = 40000000;

  typedef struct packed {
    logic             cmd;
    logic [SizeW-1:0] req_size;
    logic [AddrW-1:0] free_addr;
    logic             typed;
    logic [AddrW-1:0] want_addr;
    logic [StatW-1:0] want_status;
  } row_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [StatW-1:0] status;
  } alloc_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  buddy_block_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit          node_free [Nodes];
  int unsigned gran_order[Granules];
  bit          gran_seen [Granules];
  bit          pool_used;
  int unsigned live_addrs[$];
  alloc_rsp_t  pending_rsp[$];
  int unsigned fail_count, rsp_count, cycle_count;
  int unsigned n_alloc_ok, n_nomem, n_toobig, n_free_ok, n_ignored;
  bit          calm;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    fail_count++;
    $display("MISMATCH beat %0d: %s got %0d expected %0d", rsp_count, what, got, exp_val);
  endtask

  function automatic alloc_rsp_t pool_alloc(input int unsigned size);
    int unsigned need, k, j, n, off;
    bit          found;
    alloc_rsp_t  r;
    need  = size + HdrBytes;
    k     = MinLog;
    n     = 0;
    found = 1'b0;
    r     = '0;
    pool_used = 1'b1;
    while (k <= PoolLog && (1 << k) < need) k++;
    if (k > PoolLog) begin
      r.status = ST_TOOBIG;
      return r;
    end
    for (j = k; j <= PoolLog && !found; j++) begin
      for (n = 1 << (PoolLog - j); n < (2 << (PoolLog - j)); n++) begin
        if (node_free[n]) begin
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) begin
      r.status = ST_NOMEM;
      return r;
    end
    j--;
    node_free[n] = 1'b0;
    while (j > k) begin
      n = n << 1;
      node_free[n + 1] = 1'b1;
      j--;
    end
    off = (n - (1 << (PoolLog - k))) << k;
    gran_order[(off >> MinLog) % Granules] = k;
    gran_seen[(off >> MinLog) % Granules]  = 1'b1;
    r.addr   = AddrW'(off + HdrBytes);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic alloc_rsp_t pool_release(input int unsigned a);
    int unsigned off, k, n;
    alloc_rsp_t  r;
    r.addr   = '0;
    r.status = ST_IGNORED;
    if (a == 0 || !pool_used || a < HdrBytes) return r;
    off = a - HdrBytes;
    if (off >= PoolBytes || (off % (1 << MinLog)) != 0) return r;
    k = gran_order[off >> MinLog];
    if (k < MinLog || k > PoolLog || (off % (1 << k)) != 0) return r;
    gran_order[off >> MinLog] = 0;
    n = (1 << (PoolLog - k)) + (off >> k);
    while (n > 1 && node_free[n ^ 1]) begin
      node_free[n ^ 1] = 1'b0;
      n = n >> 1;
    end
    node_free[n] = 1'b1;
    r.status = ST_OK;
    return r;
  endfunction

  function automatic alloc_rsp_t predict_beat(input logic cmd, input int unsigned size,
                                              input int unsigned a);
    alloc_rsp_t r;
    int         idx;
    if (cmd == CMD_ALLOC) begin
      r = pool_alloc(size);
      if (r.status == ST_OK) begin
        n_alloc_ok++;
        if (r.addr != 0) live_addrs.push_back(r.addr);
      end else if (r.status == ST_NOMEM) begin
        n_nomem++;
      end else begin
        n_toobig++;
      end
    end else begin
      r = pool_release(a);
      if (r.status == ST_OK) begin
        n_free_ok++;
        idx = -1;
        foreach (live_addrs[i]) if (live_addrs[i] == a) idx = i;
        if (idx >= 0) live_addrs.delete(idx);
      end else begin
        n_ignored++;
      end
    end
    return r;
  endfunction

  // A free that passes the address checks looks up the block order of its granule,
  // which holds no defined value until some allocation has written it.
  function automatic bit reads_unwritten(input int unsigned a);
    int unsigned off;
    if (a == 0 || !pool_used || a < HdrBytes) return 1'b0;
    off = a - HdrBytes;
    if (off >= PoolBytes || (off % (1 << MinLog)) != 0) return 1'b0;
    return !gran_seen[off >> MinLog];
  endfunction

  task automatic send_beat(input row_t row);
    alloc_rsp_t r;
    int         gap;
    if (!calm && $urandom_range(0, 99) < 34) begin
      req_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= row.cmd;
    req_if.req_size  <= row.req_size;
    req_if.free_addr <= row.free_addr;
    do @(negedge clk_i); while (!req_if.ready);
    r = predict_beat(row.cmd, row.req_size, row.free_addr);
    if (row.typed && (r.addr != row.want_addr || r.status != row.want_status)) begin
      report_mismatch("directed row table entry", r, {row.want_addr, row.want_status});
    end
    pending_rsp.push_back(r);
    @(posedge clk_i);
  endtask

  function automatic row_t random_row();
    row_t        row;
    int unsigned pick;
    row  = '0;
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      row.cmd = CMD_ALLOC;
      pick    = $urandom_range(0, 99);
      if (pick < 60)      row.req_size = SizeW'($urandom_range(0, 48));
      else if (pick < 85) row.req_size = SizeW'($urandom_range(0, 500));
      else if (pick < 97) row.req_size = SizeW'($urandom_range(0, 4080));
      else                row.req_size = SizeW'($urandom_range(4081, 8191));
      row.free_addr = AddrW'($urandom);
    end else if (pick < 88 && live_addrs.size() > 0) begin
      row.cmd       = CMD_FREE;
      row.free_addr = AddrW'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      row.req_size  = SizeW'($urandom);
    end else begin
      row.cmd = CMD_FREE;
      do begin
        row.free_addr = AddrW'($urandom);
      end while (reads_unwritten(row.free_addr));
      row.req_size = SizeW'($urandom);
    end
    return row;
  endfunction

  always @(posedge clk_i) begin
    rsp_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  always @(negedge clk_i) begin
    alloc_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response beat with nothing pending, addr", rsp_if.addr, 0);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_if.addr !== exp_rsp.addr) report_mismatch("addr", rsp_if.addr, exp_rsp.addr);
        if (rsp_if.status !== exp_rsp.status) begin
          report_mismatch("status", rsp_if.status, exp_rsp.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  row_t directed[] = '{
    '{CMD_FREE,  13'd0,    12'd16,   1'b1, 12'd0,  ST_IGNORED},
    '{CMD_FREE,  13'd0,    12'd0,    1'b1, 12'd0,  ST_IGNORED},
    '{CMD_ALLOC, 13'd8191, 12'd4095, 1'b1, 12'd0,  ST_TOOBIG},
    '{CMD_ALLOC, 13'd4081, 12'd0,    1'b1, 12'd0,  ST_TOOBIG},
    '{CMD_ALLOC, 13'd4080, 12'd0,    1'b1, 12'd16, ST_OK},
    '{CMD_ALLOC, 13'd0,    12'd0,    1'b1, 12'd0,  ST_NOMEM},
    '{CMD_FREE,  13'd0,    12'd16,   1'b1, 12'd0,  ST_OK},
    '{CMD_FREE,  13'd0,    12'd16,   1'b1, 12'd0,  ST_IGNORED},
    '{CMD_ALLOC, 13'd0,    12'd0,    1'b1, 12'd16, ST_OK},
    '{CMD_ALLOC, 13'd0,    12'd0,    1'b0, 12'd0,  ST_OK},
    '{CMD_FREE,  13'd0,    12'd4095, 1'b1, 12'd0,  ST_IGNORED},
    '{CMD_FREE,  13'd0,    12'd18,   1'b1, 12'd0,  ST_IGNORED},
    '{CMD_FREE,  13'd0,    12'd8,    1'b1, 12'd0,  ST_IGNORED},
    '{CMD_ALLOC, 13'd1000, 12'd0,    1'b0, 12'd0,  ST_OK},
    '{CMD_ALLOC, 13'd2000, 12'd0,    1'b0, 12'd0,  ST_OK},
    '{CMD_FREE,  13'd0,    12'd32,   1'b0, 12'd0,  ST_OK},
    '{CMD_FREE,  13'd0,    12'd16,   1'b0, 12'd0,  ST_OK},
    '{CMD_FREE,  13'd0,    12'd1040, 1'b0, 12'd0,  ST_OK},
    '{CMD_ALLOC, 13'd4080, 12'd0,    1'b0, 12'd0,  ST_OK}
  };

  initial begin
    int unsigned waited;
    rst_ni           = 1'b0;
    calm             = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_ALLOC;
    req_if.req_size  = '0;
    req_if.free_addr = '0;
    node_free[1]     = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_beat(directed[i]);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 700 && i < 900);
      send_beat(random_row());
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
    $display("Covered %0d good allocations, %0d out of memory, %0d too large,",
             n_alloc_ok, n_nomem, n_toobig);
    $display("%0d good frees and %0d ignored frees over %0d response beats.",
             n_free_ok, n_ignored, rsp_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator.sv
tb/sv/tb_buddy_block_allocator.sv
